>>> rtl/core/u16u8_pkg.sv
package u16u8_pkg;

    localparam int QDepth = 4;
    localparam int QAddrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntW  = $clog2(QDepth + 1);

    localparam logic [5:0]  HighTag  = 6'h36;
    localparam logic [5:0]  LowTag   = 6'h37;
    localparam logic [20:0] SuppBase = 21'h10000;
    localparam logic [15:0] Lim1     = 16'h0080;
    localparam logic [15:0] Lim2     = 16'h0800;
    localparam logic [7:0]  ContMark = 8'h80;
    localparam logic [7:0]  Lead2    = 8'hC0;
    localparam logic [7:0]  Lead3    = 8'hE0;
    localparam logic [7:0]  Lead4    = 8'hF0;

    typedef enum logic [1:0] {
        KIND_CHAR,
        KIND_TERM,
        KIND_ERR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  last;
        logic [20:0] cp;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> rtl/core/u16u8_in_if.sv
interface u16u8_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;

    modport source (output valid, output code_unit, input ready);
    modport sink (input valid, input code_unit, output ready);
endinterface

>>> rtl/core/u16u8_out_if.sv
interface u16u8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_flag;
    logic       bad_string;

    modport source (output valid, output out_byte, output end_flag, output bad_string,
                    input ready);
    modport sink (input valid, input out_byte, input end_flag, input bad_string,
                  output ready);
endinterface

>>> rtl/core/u16u8_front.sv
module u16u8_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    u16u8_in_if.sink           i_in,
    input  u16u8_pkg::t_q_stat i_q_stat,
    output logic               o_push,
    output u16u8_pkg::t_job    o_job
);
    import u16u8_pkg::*;

    logic [9:0]  r_held_bits;
    logic        r_have_held;
    logic        r_skipping;
    logic [9:0]  n_held_bits;
    logic        n_have_held;
    logic        n_skipping;
    logic        w_accept;
    logic [15:0] w_u;
    logic        w_is_high;
    logic        w_is_low;
    logic        w_zero;
    logic        w_push;
    t_job        w_job;

    assign i_in.ready = !i_q_stat.full;
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_u        = i_in.code_unit;
    assign w_is_high  = (w_u[15:10] == HighTag);
    assign w_is_low   = (w_u[15:10] == LowTag);
    assign w_zero     = (w_u == 16'h0000);

    always_comb begin
        n_held_bits = r_held_bits;
        n_have_held = r_have_held;
        n_skipping  = r_skipping;
        w_push      = 1'b0;
        w_job.kind  = KIND_CHAR;
        w_job.last  = 2'd0;
        w_job.cp    = {5'd0, w_u};
        if (r_skipping) begin
            if (w_zero) begin
                n_skipping = 1'b0;
            end
        end else if (r_have_held) begin
            n_have_held = 1'b0;
            n_held_bits = 10'd0;
            w_push      = 1'b1;
            if (w_is_low) begin
                w_job.kind = KIND_CHAR;
                w_job.last = 2'd3;
                w_job.cp   = {1'b0, r_held_bits, w_u[9:0]} + SuppBase;
            end else begin
                w_job.kind = KIND_ERR;
                n_skipping = !w_zero;
            end
        end else if (w_zero) begin
            w_push     = 1'b1;
            w_job.kind = KIND_TERM;
        end else if (w_is_high) begin
            n_held_bits = w_u[9:0];
            n_have_held = 1'b1;
        end else if (w_is_low) begin
            w_push     = 1'b1;
            w_job.kind = KIND_ERR;
            n_skipping = 1'b1;
        end else begin
            w_push = 1'b1;
            if (w_u < Lim1) begin
                w_job.last = 2'd0;
            end else if (w_u < Lim2) begin
                w_job.last = 2'd1;
            end else begin
                w_job.last = 2'd2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_bits <= 10'd0;
            r_have_held <= 1'b0;
            r_skipping  <= 1'b0;
        end else if (w_accept) begin
            r_held_bits <= n_held_bits;
            r_have_held <= n_have_held;
            r_skipping  <= n_skipping;
        end
    end

    assign o_push = w_accept && w_push;
    assign o_job  = w_job;

endmodule

>>> rtl/core/u16u8_fifo.sv
module u16u8_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  u16u8_pkg::t_job    i_job,
    input  logic               i_pop,
    output u16u8_pkg::t_job    o_job,
    output u16u8_pkg::t_q_stat o_stat
);
    import u16u8_pkg::*;

    t_job              r_mem [QDepth];
    logic [QAddrW-1:0] r_wr_ptr;
    logic [QAddrW-1:0] r_rd_ptr;
    logic [QCntW-1:0]  r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_stat.full  = (r_count == QCntW'(QDepth));
    assign o_stat.empty = (r_count == '0);
    assign w_do_push    = i_push && !o_stat.full;
    assign w_do_pop     = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == QAddrW'(QDepth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAddrW'(QDepth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_do_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/core/u16u8_back.sv
module u16u8_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  u16u8_pkg::t_job    i_job,
    input  u16u8_pkg::t_q_stat i_q_stat,
    output logic               o_pop,
    u16u8_out_if.source        o_out
);
    import u16u8_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic       r_bad;
    logic       w_load;
    logic       w_last_beat;
    logic [1:0] w_shift;
    logic [5:0] w_cont;
    logic [7:0] w_byte;

    assign w_load      = (!r_valid || o_out.ready) && !i_q_stat.empty;
    assign w_last_beat = (r_idx == i_job.last);
    assign w_shift     = i_job.last - r_idx;

    always_comb begin
        case (w_shift)
            2'd1:    w_cont = i_job.cp[11:6];
            2'd2:    w_cont = i_job.cp[17:12];
            default: w_cont = i_job.cp[5:0];
        endcase
    end

    always_comb begin
        if (i_job.last == 2'd0) begin
            w_byte = (i_job.kind == KIND_CHAR) ? {1'b0, i_job.cp[6:0]} : 8'h00;
        end else if (r_idx == 2'd0) begin
            case (i_job.last)
                2'd1:    w_byte = Lead2 | {3'd0, i_job.cp[10:6]};
                2'd2:    w_byte = Lead3 | {4'd0, i_job.cp[15:12]};
                default: w_byte = Lead4 | {5'd0, i_job.cp[20:18]};
            endcase
        end else begin
            w_byte = ContMark | {2'd0, w_cont};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_idx   <= w_last_beat ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= w_byte;
            r_end  <= (i_job.kind != KIND_CHAR);
            r_bad  <= (i_job.kind == KIND_ERR);
        end
    end

    assign o_pop            = w_load && w_last_beat;
    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.end_flag   = r_end;
    assign o_out.bad_string = r_bad;

endmodule

>>> rtl/core/utf16_to_utf8_transcoder.sv
// an accepted unit's job is written to the queue, then its first byte to the output register
// throughput: one byte per cycle unless stalled or the queue is empty; 1 to 4 bytes per unit
// a four-entry job queue lets the front queue up to four jobs while bytes drain
// high surrogates and units in a dropped string push no job and give no output byte
// reset: synchronous active-low i_rst_n clears the held surrogate, skip flag, queue and output
module utf16_to_utf8_transcoder (
    input  logic         i_clk,
    input  logic         i_rst_n,
    u16u8_in_if.sink     i_in,
    u16u8_out_if.source  o_out
);
    import u16u8_pkg::*;

    t_job    w_push_job;
    t_job    w_head_job;
    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;

    u16u8_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    u16u8_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_stat  (w_q_stat)
    );

    u16u8_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (w_head_job),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

`ifndef SYNTH
    a_bad_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.bad_string |-> o_out.end_flag)
        else $error("error beat without end flag");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.end_flag |-> o_out.out_byte == 8'h00)
        else $error("end beat with nonzero byte");

    a_q_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_stat.full && w_q_stat.empty))
        else $error("queue both full and empty");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

>>> tb/tb_utf16_to_utf8_transcoder.sv
`timescale 1ns / 100ps

module tb_utf16_to_utf8_transcoder;
    import u16u8_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       bad;
    } t_utf8_beat;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u16u8_in_if  in_bus ();
    u16u8_out_if out_bus ();

    utf16_to_utf8_transcoder u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #4 i_clk = ~i_clk;

    // expected utf-8 beats, oldest first
    t_utf8_beat utf8_expected[$];

    // transcoder state mirror
    logic [9:0] held_high;
    logic       high_pending;
    logic       dropping;

    int  n_errors      = 0;
    int  units_sent    = 0;
    int  units_live    = 0;
    int  bytes_checked = 0;
    int  strings_sent  = 0;
    int  bad_strings   = 0;
    bit  tx_quiet      = 1'b0;
    bit  rx_quiet      = 1'b0;
    bit  long_stall_req = 1'b0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    task automatic emit_beat(input logic [7:0] data, input logic last, input logic bad);
        t_utf8_beat b;
        b.data = data;
        b.last = last;
        b.bad  = bad;
        utf8_expected.push_back(b);
        if (bad) bad_strings++;
    endtask

    task automatic encode_code_point(input logic [20:0] cp);
        if (cp < 21'(Lim1)) begin
            emit_beat(cp[7:0], 1'b0, 1'b0);
        end else if (cp < 21'(Lim2)) begin
            emit_beat(Lead2 | {3'b000, cp[10:6]}, 1'b0, 1'b0);
            emit_beat(ContMark | {2'b00, cp[5:0]}, 1'b0, 1'b0);
        end else if (cp < SuppBase) begin
            emit_beat(Lead3 | {4'b0000, cp[15:12]}, 1'b0, 1'b0);
            emit_beat(ContMark | {2'b00, cp[11:6]}, 1'b0, 1'b0);
            emit_beat(ContMark | {2'b00, cp[5:0]}, 1'b0, 1'b0);
        end else begin
            emit_beat(Lead4 | {5'b00000, cp[20:18]}, 1'b0, 1'b0);
            emit_beat(ContMark | {2'b00, cp[17:12]}, 1'b0, 1'b0);
            emit_beat(ContMark | {2'b00, cp[11:6]}, 1'b0, 1'b0);
            emit_beat(ContMark | {2'b00, cp[5:0]}, 1'b0, 1'b0);
        end
    endtask

    task automatic transcode_unit(input logic [15:0] unit);
        logic is_high;
        logic is_low;
        is_high = (unit[15:10] == HighTag);
        is_low  = (unit[15:10] == LowTag);
        if (dropping) begin
            if (unit == 16'h0000) dropping = 1'b0;
            return;
        end
        units_live++;
        if (high_pending) begin
            high_pending = 1'b0;
            if (is_low) begin
                encode_code_point(SuppBase + {1'b0, held_high, unit[9:0]});
            end else begin
                dropping = (unit != 16'h0000);
                emit_beat(8'h00, 1'b1, 1'b1);
            end
            held_high = '0;
        end else if (unit == 16'h0000) begin
            emit_beat(8'h00, 1'b1, 1'b0);
        end else if (is_high) begin
            held_high    = unit[9:0];
            high_pending = 1'b1;
        end else if (is_low) begin
            dropping = 1'b1;
            emit_beat(8'h00, 1'b1, 1'b1);
        end else begin
            encode_code_point({5'b00000, unit});
        end
    endtask

    task automatic send_unit(input logic [15:0] unit);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.code_unit <= unit;
        do @(posedge i_clk); while (!in_bus.ready);
        transcode_unit(unit);
        units_sent++;
        if (unit == 16'h0000) strings_sent++;
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        do @(posedge i_clk); while (utf8_expected.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_plain_ranges();
        send_unit(16'h0041);
        send_unit(16'h007f);
        send_unit(16'h0080);
        send_unit(16'h07ff);
        send_unit(16'h0800);
        send_unit(16'hd7ff);
        send_unit(16'he000);
        send_unit(16'hffff);
        send_unit(16'h0000);
        wait_drained();
    endtask

    task automatic test_surrogates();
        // lowest and highest supplementary points
        send_unit(16'hd800);
        send_unit(16'hdc00);
        send_unit(16'hdbff);
        send_unit(16'hdfff);
        send_unit(16'h0000);
        // lone low, rest of string dropped including a high
        send_unit(16'hdc00);
        send_unit(16'h0041);
        send_unit(16'hd800);
        send_unit(16'h0000);
        // high then ordinary unit
        send_unit(16'hd800);
        send_unit(16'h0041);
        send_unit(16'h0000);
        // high then terminator ends the string
        send_unit(16'hdbff);
        send_unit(16'h0000);
        // high then high
        send_unit(16'hd800);
        send_unit(16'hdbff);
        send_unit(16'h0000);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        tx_quiet = 1'b1;
        long_stall_req <= ~long_stall_req;
        repeat (16) send_unit(16'h20ac);
        send_unit(16'h0000);
        tx_quiet = 1'b0;
        wait_drained();
    endtask

    task automatic test_streaming();
        tx_quiet = 1'b1;
        rx_quiet <= 1'b1;
        for (int i = 0; i < 6; i++) begin
            send_unit(16'(i + 16'h0061));
            send_unit(16'h00e9);
            send_unit(16'hd83d);
            send_unit(16'hde00);
        end
        send_unit(16'h0000);
        wait_drained();
        tx_quiet = 1'b0;
        rx_quiet <= 1'b0;
    endtask

    task automatic send_random_string();
        int len;
        int kind;
        int r;
        bit ended;
        ended = 1'b0;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
        for (int i = 0; i < len && !ended; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                send_unit(16'($urandom_range(1, 16'h007f)));
            end else if (kind < 50) begin
                send_unit(16'($urandom_range(16'h0080, 16'h07ff)));
            end else if (kind < 70) begin
                r = $urandom_range(16'h0800, 16'hf7ff);
                if (r >= 16'hd800) r += 16'h0800;
                send_unit(16'(r));
            end else if (kind < 88) begin
                send_unit({HighTag, 10'($urandom)});
                send_unit({LowTag, 10'($urandom)});
            end else if (kind < 92) begin
                r = $urandom_range(0, 16'hffff);
                send_unit(16'(r));
                ended = (r == 0);
            end else if (kind < 95) begin
                send_unit({LowTag, 10'($urandom)});
            end else if (kind < 98) begin
                send_unit({HighTag, 10'($urandom)});
                if ($urandom_range(0, 1) == 0) send_unit({HighTag, 10'($urandom)});
                else send_unit(16'($urandom_range(1, 16'hd7ff)));
            end else begin
                send_unit({HighTag, 10'($urandom)});
                send_unit(16'h0000);
                ended = 1'b1;
            end
        end
        if (!ended) send_unit(16'h0000);
        if ($urandom_range(0, 11) == 0) wait_drained();
    endtask

    task automatic test_random_strings(input int target);
        int start;
        start = units_live;
        while (units_live - start < target) send_random_string();
        wait_drained();
    endtask

    // output sink: random stalls plus one long hold-off on request
    initial begin
        int  rx_wait;
        bit  long_stall_seen;
        rx_wait = 0;
        long_stall_seen = 1'b0;
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_wait > 0) begin
                out_bus.ready <= 1'b0;
                rx_wait--;
            end else if (long_stall_req != long_stall_seen) begin
                long_stall_seen = long_stall_req;
                rx_wait = 300;
                out_bus.ready <= 1'b0;
            end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
                rx_wait = pick_gap();
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_utf8_beat want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            bytes_checked++;
            if (utf8_expected.size() == 0) begin
                report_mismatch($sformatf("unexpected beat %02h last %0b bad %0b",
                    out_bus.out_byte, out_bus.end_flag, out_bus.bad_string));
            end else begin
                want = utf8_expected.pop_front();
                if (out_bus.out_byte !== want.data)
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                        out_bus.out_byte, want.data));
                if (out_bus.end_flag !== want.last)
                    report_mismatch($sformatf("end_flag %0b, expected %0b",
                        out_bus.end_flag, want.last));
                if (out_bus.bad_string !== want.bad)
                    report_mismatch($sformatf("bad_string %0b, expected %0b",
                        out_bus.bad_string, want.bad));
            end
        end
    end

    initial begin
        #4000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        held_high    = '0;
        high_pending = 1'b0;
        dropping     = 1'b0;
        i_rst_n          <= 1'b0;
        in_bus.valid     <= 1'b0;
        in_bus.code_unit <= 16'h0000;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_ranges();
        test_surrogates();
        test_output_backpressure();
        test_streaming();
        test_random_strings(125);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (utf8_expected.size() != 0)
            report_mismatch($sformatf("%0d beats never arrived", utf8_expected.size()));
        $display("sent %0d code units in %0d strings, %0d of them live", units_sent,
            strings_sent, units_live);
        $display("checked %0d utf-8 beats, %0d invalid strings flagged", bytes_checked,
            bad_strings);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/u16u8_pkg.sv
rtl/core/u16u8_in_if.sv
rtl/core/u16u8_out_if.sv
rtl/core/u16u8_front.sv
rtl/core/u16u8_fifo.sv
rtl/core/u16u8_back.sv
rtl/core/utf16_to_utf8_transcoder.sv
tb/tb_utf16_to_utf8_transcoder.sv
